// ===== sv/refcounted_pool_deferred_reclaim_defines.svh =====
// assertion macros for the slot pool
`ifndef REFCOUNTED_POOL_DEFERRED_RECLAIM_DEFINES_SVH
`define REFCOUNTED_POOL_DEFERRED_RECLAIM_DEFINES_SVH

// condition holds at every edge out of reset
`define RPDR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("slot pool check failed");

// implication in the same cycle
`define RPDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot pool check failed");

// implication in the next cycle
`define RPDR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot pool check failed");

`endif

// ===== sv/rpdr_pkg.sv =====
package rpdr_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FREED_W  = 9;
  localparam int unsigned FIF_W    = 2;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADDREF = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REL    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QOVF      = 3'd4;

  localparam logic [FIF_W-1:0] FIF_RESET = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_ALLOC,
    S_ADD_POP,
    S_ADD_SET,
    S_REF_RD,
    S_REF_MOD,
    S_FRM_HEAD,
    S_FRM_TEST,
    S_FRM_CHK,
    S_FRM_PUSH_RD,
    S_FRM_PUSH_WR,
    S_DONE
  } state_t;

endpackage

// ===== sv/rpdr_slot_store.sv =====
module rpdr_slot_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 88
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== sv/rpdr_pend_queue.sv =====
module rpdr_pend_queue #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned SW    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  logic [SW-1:0]                        push_slot,
  input  logic [rpdr_pkg::FRAME_W-1:0]         push_frame,
  input  logic                                 pop,
  input  logic                                 rd_en,
  output logic [SW-1:0]                        rd_slot,
  output logic [rpdr_pkg::FRAME_W-1:0]         rd_frame,
  output logic [$clog2(DEPTH+1)-1:0]           count
);
  import rpdr_pkg::*;

  localparam int unsigned QW  = $clog2(DEPTH);
  localparam int unsigned QCW = $clog2(DEPTH + 1);

  logic [SW+FRAME_W-1:0] mem [DEPTH];
  logic [SW+FRAME_W-1:0] rd_word_r;
  logic [QW-1:0]         head_r, head_nxt;
  logic [QW-1:0]         tail_r, tail_nxt;
  logic [QCW-1:0]        cnt_r, cnt_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == QW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end else if (pop) begin
      head_nxt = (head_r == QW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= {push_slot, push_frame};
    end
    if (rd_en) begin
      rd_word_r <= mem[head_r];
    end
  end

  assign rd_slot  = rd_word_r[SW+FRAME_W-1:FRAME_W];
  assign rd_frame = rd_word_r[FRAME_W-1:0];
  assign count    = cnt_r;

endmodule

// ===== sv/refcounted_pool_deferred_reclaim.sv =====
// channel | handshake           | beat fields
// input   | in_valid/in_ready   | in_cmd, in_content_hash, in_slot_index, in_frame_number
// result  | out_valid/out_ready | out_result_index, out_found_existing, out_status, out_freed_count
// config  | cfg_wr_en           | cfg_wr_data
//
// one command at a time, sequenced over the single-port slot memory
// add: hash scan (one slot read per cycle), then a free-slot allocation if no hash matches
// addref / release: read the slot, then write the new count; new frame: drain ripe queue entries
// after reset a clearing pass over all PAGE_SIZE*NUM_PAGES slots holds in_ready low
// a waiting result beat holds the next command in S_DONE, not its input beat
module refcounted_pool_deferred_reclaim #(
  parameter int unsigned PAGE_SIZE   = 64,
  parameter int unsigned NUM_PAGES   = 4,
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned REF_WIDTH   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rpdr_pkg::CMD_W-1:0]        in_cmd,
  input  logic [rpdr_pkg::HASH_W-1:0]       in_content_hash,
  input  logic [rpdr_pkg::IDX_W-1:0]        in_slot_index,
  input  logic [rpdr_pkg::FRAME_W-1:0]      in_frame_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rpdr_pkg::IDX_W-1:0]        out_result_index,
  output logic                              out_found_existing,
  output logic [rpdr_pkg::STATUS_W-1:0]     out_status,
  output logic [rpdr_pkg::FREED_W-1:0]      out_freed_count,
  input  logic                              cfg_wr_en,
  input  logic [rpdr_pkg::FIF_W-1:0]        cfg_wr_data
);
  import rpdr_pkg::*;
`include "refcounted_pool_deferred_reclaim_defines.svh"

  localparam int unsigned TOTAL = PAGE_SIZE * NUM_PAGES;
  localparam int unsigned SW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned IW    = SW + 1;
  localparam int unsigned LW    = $clog2(PAGE_SIZE);
  localparam int unsigned PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned TW    = $clog2(PAGE_SIZE + 1);
  localparam int unsigned QCW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CW    = SW + IDX_W + 1;
  localparam int unsigned DW    = 1 + REF_WIDTH + HASH_W + LW;
  localparam logic [REF_WIDTH-1:0] REF_MAX = '1;

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic [FRAME_W-1:0]  cur_frame_r, cur_frame_nxt;
  logic [FIF_W-1:0]    fif_r;
  logic [IW-1:0]       scan_r, scan_nxt;
  logic [SW-1:0]       chk_r, chk_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [SW-1:0]       idx_r, idx_nxt;
  logic [PW-1:0]       pg_r, pg_nxt;
  logic [IW-1:0]       clr_r, clr_nxt;
  logic [LW-1:0]       clr_loc_r, clr_loc_nxt;
  logic [IDX_W-1:0]    w_idx_r, w_idx_nxt;
  logic                w_found_r, w_found_nxt;
  logic [STATUS_W-1:0] w_status_r, w_status_nxt;
  logic [FREED_W-1:0]  freed_r, freed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_found_r, out_found_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FREED_W-1:0]  out_freed_r, out_freed_nxt;
  logic [TW-1:0]       top_r [NUM_PAGES];

  logic                sm_en, sm_we;
  logic [SW-1:0]       sm_addr;
  logic [DW-1:0]       sm_wdata, sm_rdata;
  logic                q_push, q_pop, q_rd;
  logic [SW-1:0]       q_slot;
  logic [FRAME_W-1:0]  q_frame;
  logic [QCW-1:0]      q_count;
  logic                top_dec, top_inc;

  logic                rd_valid;
  logic [REF_WIDTH-1:0] rd_ref;
  logic [HASH_W-1:0]   rd_hash;
  logic [LW-1:0]       rd_fs;
  logic                any_free;
  logic [PW-1:0]       alloc_pg;
  logic [SW-1:0]       alloc_pos;
  logic [SW-1:0]       pg_base;
  logic [PW-1:0]       idx_pg;
  logic [SW-1:0]       idx_base;
  logic [TW-1:0]       top_sel;
  logic                in_range;
  logic                ripe;
  logic                load_out;

  assign rd_valid = sm_rdata[DW-1];
  assign rd_ref   = sm_rdata[DW-2 -: REF_WIDTH];
  assign rd_hash  = sm_rdata[LW +: HASH_W];
  assign rd_fs    = sm_rdata[LW-1:0];
  assign top_sel  = top_r[pg_r];
  assign in_range = CW'(slot_r) < CW'(TOTAL);
  assign ripe     = ({1'b0, q_frame} + (FRAME_W + 1)'(fif_r)) < {1'b0, cur_frame_r};

  always_comb begin
    any_free  = 1'b0;
    alloc_pg  = '0;
    alloc_pos = '0;
    for (int p = NUM_PAGES - 1; p >= 0; p--) begin
      if (top_r[p] != '0) begin
        any_free  = 1'b1;
        alloc_pg  = PW'(p);
        alloc_pos = SW'(p * PAGE_SIZE) + SW'(top_r[p] - 1'b1);
      end
    end
  end

  always_comb begin
    pg_base  = '0;
    idx_pg   = '0;
    idx_base = '0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      if (pg_r == PW'(p)) begin
        pg_base = SW'(p * PAGE_SIZE);
      end
      if (IW'(idx_r) >= IW'(p * PAGE_SIZE)) begin
        idx_pg   = PW'(p);
        idx_base = SW'(p * PAGE_SIZE);
      end
    end
  end

  rpdr_slot_store #(
    .DEPTH (TOTAL),
    .AW    (SW),
    .DW    (DW)
  ) u_slot_store (
    .clk   (clk),
    .en    (sm_en),
    .we    (sm_we),
    .addr  (sm_addr),
    .wdata (sm_wdata),
    .rdata (sm_rdata)
  );

  rpdr_pend_queue #(
    .DEPTH (QUEUE_DEPTH),
    .SW    (SW)
  ) u_pend_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_slot  (idx_r),
    .push_frame (cur_frame_r),
    .pop        (q_pop),
    .rd_en      (q_rd),
    .rd_slot    (q_slot),
    .rd_frame   (q_frame),
    .count      (q_count)
  );

  // next state and working registers
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    hash_nxt      = hash_r;
    slot_nxt      = slot_r;
    cur_frame_nxt = cur_frame_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    chk_v_nxt     = chk_v_r;
    idx_nxt       = idx_r;
    pg_nxt        = pg_r;
    clr_nxt       = clr_r;
    clr_loc_nxt   = clr_loc_r;
    w_idx_nxt     = w_idx_r;
    w_found_nxt   = w_found_r;
    w_status_nxt  = w_status_r;
    freed_nxt     = freed_r;
    load_out      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_nxt     = clr_r + 1'b1;
        clr_loc_nxt = (clr_loc_r == LW'(PAGE_SIZE - 1)) ? '0 : clr_loc_r + 1'b1;
        if (clr_r == IW'(TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_cmd;
          hash_nxt     = in_content_hash;
          slot_nxt     = in_slot_index;
          w_idx_nxt    = '0;
          w_found_nxt  = 1'b0;
          w_status_nxt = ST_OK;
          freed_nxt    = '0;
          scan_nxt     = '0;
          chk_v_nxt    = 1'b0;
          case (in_cmd)
            CMD_ADD: state_nxt = S_ADD_SCAN;
            CMD_ADDREF, CMD_REL: state_nxt = S_REF_RD;
            CMD_FRAME: begin
              cur_frame_nxt = in_frame_number;
              state_nxt     = S_FRM_HEAD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_SCAN: begin
        if (chk_v_r && rd_valid && (rd_hash == hash_r)) begin
          w_idx_nxt   = IDX_W'(chk_r);
          w_found_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else if (scan_r < IW'(TOTAL)) begin
          chk_nxt   = SW'(scan_r);
          chk_v_nxt = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end else begin
          state_nxt = S_ADD_ALLOC;
        end
      end
      S_ADD_ALLOC: begin
        if (!any_free) begin
          w_status_nxt = ST_POOL_FULL;
          state_nxt    = S_DONE;
        end else begin
          pg_nxt    = alloc_pg;
          state_nxt = S_ADD_POP;
        end
      end
      S_ADD_POP: begin
        idx_nxt   = pg_base + SW'(rd_fs);
        state_nxt = S_ADD_SET;
      end
      S_ADD_SET: begin
        w_idx_nxt = IDX_W'(idx_r);
        state_nxt = S_DONE;
      end
      S_REF_RD: begin
        idx_nxt   = SW'(slot_r);
        state_nxt = in_range ? S_REF_MOD : S_DONE;
      end
      S_REF_MOD: begin
        if (cmd_r == CMD_ADDREF) begin
          if (rd_ref == REF_MAX) begin
            w_status_nxt = ST_SATURATED;
          end
        end else if (rd_ref == '0) begin
          w_status_nxt = ST_UNDERFLOW;
        end else if ((rd_ref == REF_WIDTH'(1)) && (q_count == QCW'(QUEUE_DEPTH))) begin
          w_status_nxt = ST_QOVF;
        end
        state_nxt = S_DONE;
      end
      S_FRM_HEAD: begin
        state_nxt = (q_count == '0) ? S_DONE : S_FRM_TEST;
      end
      S_FRM_TEST: begin
        if (ripe) begin
          idx_nxt   = q_slot;
          state_nxt = S_FRM_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FRM_CHK: begin
        if (rd_valid && (rd_ref == '0)) begin
          freed_nxt = freed_r + 1'b1;
          pg_nxt    = idx_pg;
          state_nxt = (top_r[idx_pg] < TW'(PAGE_SIZE)) ? S_FRM_PUSH_RD : S_FRM_HEAD;
        end else begin
          state_nxt = S_FRM_HEAD;
        end
      end
      S_FRM_PUSH_RD: state_nxt = S_FRM_PUSH_WR;
      S_FRM_PUSH_WR: state_nxt = S_FRM_HEAD;
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory and queue controls
  always_comb begin
    sm_en    = 1'b0;
    sm_we    = 1'b0;
    sm_addr  = '0;
    sm_wdata = '0;
    q_push   = 1'b0;
    q_pop    = 1'b0;
    q_rd     = 1'b0;
    top_dec  = 1'b0;
    top_inc  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        sm_en    = 1'b1;
        sm_we    = 1'b1;
        sm_addr  = SW'(clr_r);
        sm_wdata = {1'b0, {REF_WIDTH{1'b0}}, {HASH_W{1'b0}}, clr_loc_r};
      end
      S_ADD_SCAN: begin
        if (!(chk_v_r && rd_valid && (rd_hash == hash_r)) && (scan_r < IW'(TOTAL))) begin
          sm_en   = 1'b1;
          sm_addr = SW'(scan_r);
        end
      end
      S_ADD_ALLOC: begin
        if (any_free) begin
          sm_en   = 1'b1;
          sm_addr = alloc_pos;
          top_dec = 1'b1;
        end
      end
      S_ADD_POP: begin
        sm_en   = 1'b1;
        sm_addr = pg_base + SW'(rd_fs);
      end
      S_ADD_SET: begin
        sm_en    = 1'b1;
        sm_we    = 1'b1;
        sm_addr  = idx_r;
        sm_wdata = {1'b1, rd_ref, hash_r, rd_fs};
      end
      S_REF_RD: begin
        if (in_range) begin
          sm_en   = 1'b1;
          sm_addr = SW'(slot_r);
        end
      end
      S_REF_MOD: begin
        sm_addr = idx_r;
        if (cmd_r == CMD_ADDREF) begin
          if (rd_ref != REF_MAX) begin
            sm_en    = 1'b1;
            sm_we    = 1'b1;
            sm_wdata = {rd_valid, rd_ref + 1'b1, rd_hash, rd_fs};
          end
        end else if (rd_ref != '0) begin
          sm_en    = 1'b1;
          sm_we    = 1'b1;
          sm_wdata = {rd_valid, rd_ref - 1'b1, rd_hash, rd_fs};
          q_push   = (rd_ref == REF_WIDTH'(1)) && (q_count != QCW'(QUEUE_DEPTH));
        end
      end
      S_FRM_HEAD: begin
        q_rd = (q_count != '0);
      end
      S_FRM_TEST: begin
        if (ripe) begin
          q_pop   = 1'b1;
          sm_en   = 1'b1;
          sm_addr = q_slot;
        end
      end
      S_FRM_CHK: begin
        if (rd_valid && (rd_ref == '0)) begin
          sm_en    = 1'b1;
          sm_we    = 1'b1;
          sm_addr  = idx_r;
          sm_wdata = {1'b0, rd_ref, rd_hash, rd_fs};
        end
      end
      S_FRM_PUSH_RD: begin
        sm_en   = 1'b1;
        sm_addr = pg_base + SW'(top_sel);
      end
      S_FRM_PUSH_WR: begin
        sm_en    = 1'b1;
        sm_we    = 1'b1;
        sm_addr  = pg_base + SW'(top_sel);
        sm_wdata = {rd_valid, rd_ref, rd_hash, LW'(idx_r - idx_base)};
        top_inc  = 1'b1;
      end
      default: begin
        sm_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_idx_nxt    = out_idx_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_freed_nxt  = out_freed_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_idx_nxt    = w_idx_r;
      out_found_nxt  = w_found_r;
      out_status_nxt = w_status_r;
      out_freed_nxt  = freed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_loc_r   <= '0;
      out_valid_r <= 1'b0;
      fif_r       <= FIF_RESET;
      cur_frame_r <= '0;
      chk_v_r     <= 1'b0;
      for (int p = 0; p < NUM_PAGES; p++) begin
        top_r[p] <= TW'(PAGE_SIZE);
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_loc_r   <= clr_loc_nxt;
      out_valid_r <= out_valid_nxt;
      cur_frame_r <= cur_frame_nxt;
      chk_v_r     <= chk_v_nxt;
      if (cfg_wr_en) begin
        fif_r <= cfg_wr_data;
      end
      if (top_dec) begin
        top_r[alloc_pg] <= top_r[alloc_pg] - 1'b1;
      end else if (top_inc) begin
        top_r[pg_r] <= top_sel + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    hash_r       <= hash_nxt;
    slot_r       <= slot_nxt;
    scan_r       <= scan_nxt;
    chk_r        <= chk_nxt;
    idx_r        <= idx_nxt;
    pg_r         <= pg_nxt;
    w_idx_r      <= w_idx_nxt;
    w_found_r    <= w_found_nxt;
    w_status_r   <= w_status_nxt;
    freed_r      <= freed_nxt;
    out_idx_r    <= out_idx_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_freed_r  <= out_freed_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_index   = out_idx_r;
  assign out_found_existing = out_found_r;
  assign out_status         = out_status_r;
  assign out_freed_count    = out_freed_r;

  `RPDR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `RPDR_ASSERT_ALWAYS(a_queue_bound, q_count <= QCW'(QUEUE_DEPTH))
  `RPDR_ASSERT_IMP(a_no_write_idle, state_r == S_IDLE, !sm_en)
  `RPDR_ASSERT_IMP(a_no_push_pop, q_push, !q_pop)
  `RPDR_ASSERT_IMP(a_status_code, out_valid_r, out_status_r <= ST_QOVF)

endmodule

// ===== tb/refcounted_pool_deferred_reclaim_test.sv =====
`timescale 1ns / 100ps

module refcounted_pool_deferred_reclaim_test;
  import rpdr_pkg::*;

  localparam int unsigned PAGE_SIZE   = 64;
  localparam int unsigned NUM_PAGES   = 4;
  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned REF_WIDTH   = 16;
  localparam int unsigned TOTAL_SLOTS = PAGE_SIZE * NUM_PAGES;
  localparam logic [REF_WIDTH-1:0] REF_MAX = '1;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [IDX_W-1:0]    result_index;
    logic                found_existing;
    logic [STATUS_W-1:0] status;
    logic [FREED_W-1:0]  freed_count;
  } pool_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd;
  logic [HASH_W-1:0] in_content_hash;
  logic [IDX_W-1:0] in_slot_index;
  logic [FRAME_W-1:0] in_frame_number;
  logic out_valid;
  logic out_ready;
  logic [IDX_W-1:0] out_result_index;
  logic out_found_existing;
  logic [STATUS_W-1:0] out_status;
  logic [FREED_W-1:0] out_freed_count;
  logic cfg_wr_en;
  logic [FIF_W-1:0] cfg_wr_data;

  // pool model
  logic               pool_valid [TOTAL_SLOTS];
  logic [HASH_W-1:0]  pool_hash [TOTAL_SLOTS];
  logic [REF_WIDTH-1:0] pool_refs [TOTAL_SLOTS];
  int unsigned        pool_stack [TOTAL_SLOTS];
  int unsigned        pool_top [NUM_PAGES];
  logic [IDX_W-1:0]   reclaim_slot [QUEUE_DEPTH];
  logic [FRAME_W-1:0] reclaim_frame [QUEUE_DEPTH];
  int unsigned        reclaim_head;
  int unsigned        reclaim_count;
  logic [FRAME_W-1:0] frame_now;
  logic [FIF_W-1:0]   frames_delay;

  pool_result_t expected_results[$];
  logic [IDX_W-1:0] handed_out[$];
  int unsigned errors;
  int unsigned cycles;
  bit no_idle;

  refcounted_pool_deferred_reclaim DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_content_hash(in_content_hash),
    .in_slot_index(in_slot_index),
    .in_frame_number(in_frame_number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result_index(out_result_index),
    .out_found_existing(out_found_existing),
    .out_status(out_status),
    .out_freed_count(out_freed_count),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic pool_reset();
    for (int s = 0; s < TOTAL_SLOTS; s++) begin
      pool_valid[s] = 1'b0;
      pool_refs[s] = '0;
      pool_stack[s] = s % PAGE_SIZE;
    end
    for (int p = 0; p < NUM_PAGES; p++) pool_top[p] = PAGE_SIZE;
    reclaim_head = 0;
    reclaim_count = 0;
    frame_now = '0;
    frames_delay = FIF_RESET;
  endtask

  task automatic pool_predict(input logic [CMD_W-1:0] cmd, input logic [HASH_W-1:0] hash,
                              input logic [IDX_W-1:0] slot, input logic [FRAME_W-1:0] frame,
                              output pool_result_t res);
    bit done;
    int unsigned s;
    int unsigned freed;
    res = '0;
    done = 0;
    freed = 0;
    case (cmd)
      CMD_ADD: begin
        for (int i = 0; i < TOTAL_SLOTS && !done; i++) begin
          if (pool_valid[i] && pool_hash[i] == hash) begin
            res.result_index = IDX_W'(i);
            res.found_existing = 1'b1;
            done = 1;
          end
        end
        for (int p = 0; p < NUM_PAGES && !done; p++) begin
          if (pool_top[p] > 0) begin
            pool_top[p]--;
            s = p * PAGE_SIZE + pool_stack[p * PAGE_SIZE + pool_top[p]];
            res.result_index = IDX_W'(s);
            pool_valid[s] = 1'b1;
            pool_hash[s] = hash;
            done = 1;
          end
        end
        if (!done) res.status = ST_POOL_FULL;
      end
      CMD_ADDREF: begin
        if (pool_refs[slot] == REF_MAX) res.status = ST_SATURATED;
        else pool_refs[slot]++;
      end
      CMD_REL: begin
        if (pool_refs[slot] == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          pool_refs[slot]--;
          if (pool_refs[slot] == 0) begin
            if (reclaim_count >= QUEUE_DEPTH) begin
              res.status = ST_QOVF;
            end else begin
              s = (reclaim_head + reclaim_count) % QUEUE_DEPTH;
              reclaim_slot[s] = slot;
              reclaim_frame[s] = frame_now;
              reclaim_count++;
            end
          end
        end
      end
      default: begin
        frame_now = frame;
        while (reclaim_count > 0 &&
               ({32'd0, reclaim_frame[reclaim_head]} + {62'd0, frames_delay}) <
               {32'd0, frame_now}) begin
          s = {24'd0, reclaim_slot[reclaim_head]};
          if (pool_refs[s] == 0 && pool_valid[s]) begin
            pool_valid[s] = 1'b0;
            if (pool_top[s / PAGE_SIZE] < PAGE_SIZE) begin
              pool_stack[(s / PAGE_SIZE) * PAGE_SIZE + pool_top[s / PAGE_SIZE]] = s % PAGE_SIZE;
              pool_top[s / PAGE_SIZE]++;
            end
            freed++;
          end
          reclaim_head = (reclaim_head + 1) % QUEUE_DEPTH;
          reclaim_count--;
        end
        res.freed_count = FREED_W'(freed);
      end
    endcase
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [HASH_W-1:0] hash,
                              input logic [IDX_W-1:0] slot, input logic [FRAME_W-1:0] frame);
    int unsigned gap;
    pool_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd = cmd;
    in_content_hash = hash;
    in_slot_index = slot;
    in_frame_number = frame;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pool_predict(cmd, hash, slot, frame, res);
    expected_results = {expected_results, res};
    if (cmd == CMD_ADD && res.status == ST_OK) handed_out = {handed_out, res.result_index};
    @(negedge clk);
  endtask

  task automatic drain_and_config(input logic [FIF_W-1:0] value);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_data = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    frames_delay = value;
  endtask

  // result side with random stalls
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 16);
      out_ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat index=%0d", $time, out_result_index);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_result_index !== want.result_index) begin
          $display("%0t: result_index expected %0d actual %0d", $time, want.result_index,
                   out_result_index);
          errors++;
        end
        if (out_found_existing !== want.found_existing) begin
          $display("%0t: found_existing expected %0d actual %0d", $time,
                   want.found_existing, out_found_existing);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_freed_count !== want.freed_count) begin
          $display("%0t: freed_count expected %0d actual %0d", $time, want.freed_count,
                   out_freed_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_basic_commands();
    send_command(CMD_ADD, 64'd0, 8'd0, 32'd0);
    send_command(CMD_ADD, '1, 8'd0, 32'd0);
    send_command(CMD_ADD, 64'd0, 8'hff, '1);
    send_command(CMD_ADDREF, 64'd0, 8'd63, 32'd0);
    send_command(CMD_ADDREF, 64'd0, 8'd63, 32'd0);
    send_command(CMD_REL, 64'd0, 8'd63, 32'd0);
    send_command(CMD_REL, 64'd0, 8'd63, 32'd0);
    send_command(CMD_REL, 64'd0, 8'd63, 32'd0);
    send_command(CMD_ADDREF, 64'd0, 8'd200, 32'd0);
    send_command(CMD_REL, 64'd0, 8'd200, 32'd0);
    send_command(CMD_FRAME, 64'd0, 8'd0, 32'd2);
    send_command(CMD_FRAME, 64'd0, 8'd0, 32'd3);
    send_command(CMD_ADD, 64'd0, 8'd0, 32'd0);
    send_command(CMD_ADDREF, 64'd0, 8'd62, 32'd0);
    send_command(CMD_REL, 64'd0, 8'd62, 32'd0);
    send_command(CMD_FRAME, 64'd0, 8'd0, '1);
    send_command(CMD_FRAME, 64'd0, 8'd0, 32'd0);
  endtask

  task automatic test_frame_delays();
    for (int d = 0; d < 4; d++) begin
      drain_and_config(FIF_W'(d));
      for (int k = 0; k < 3; k++) begin
        send_command(CMD_ADD, {$urandom, $urandom}, 8'd0, 32'd0);
        send_command(CMD_ADDREF, 64'd0, handed_out[$], 32'd0);
        send_command(CMD_REL, 64'd0, handed_out[$], 32'd0);
        send_command(CMD_FRAME, 64'd0, 8'd0, frame_now + $urandom_range(0, 2));
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    logic [IDX_W-1:0] slot;
    logic [HASH_W-1:0] hash;
    for (int n = 0; n < 60; n++) begin
      if (n % 20 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 30 == 29) drain_and_config(FIF_W'($urandom_range(0, 3)));
      pick = $urandom_range(0, 99);
      if (handed_out.size() != 0 && $urandom_range(0, 3) != 0)
        slot = handed_out[$urandom_range(0, handed_out.size() - 1)];
      else
        slot = IDX_W'($urandom_range(0, 255));
      hash = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} :
                                           HASH_W'($urandom_range(0, 15));
      if (pick < 30)
        send_command(CMD_ADD, hash, IDX_W'($urandom_range(0, 255)), $urandom);
      else if (pick < 58)
        send_command(CMD_ADDREF, {$urandom, $urandom}, slot, $urandom);
      else if (pick < 86)
        send_command(CMD_REL, {$urandom, $urandom}, slot, $urandom);
      else if (pick < 97)
        send_command(CMD_FRAME, {$urandom, $urandom}, slot, frame_now + $urandom_range(0, 3));
      else
        send_command(CMD_FRAME, {$urandom, $urandom}, slot, $urandom);
    end
    no_idle = 0;
  endtask

  task automatic test_queue_overflow();
    logic [IDX_W-1:0] slot;
    slot = '0;
    // a slot with no references, so each release brings it back to zero
    for (int s = TOTAL_SLOTS - 1; s >= 0; s--) begin
      if (pool_refs[s] == '0) slot = IDX_W'(s);
    end
    for (int k = 0; k < QUEUE_DEPTH + 2; k++) begin
      send_command(CMD_ADDREF, 64'd0, slot, 32'd0);
      send_command(CMD_REL, 64'd0, slot, 32'd0);
    end
    send_command(CMD_FRAME, 64'd0, 8'd0, frame_now + 32'd8);
  endtask

  task automatic test_pool_full();
    int unsigned room;
    room = 0;
    for (int p = 0; p < NUM_PAGES; p++) room += pool_top[p];
    drain_and_config(2'd3);
    for (int k = 0; k < int'(room) + 2; k++) begin
      no_idle = (k % 16 != 0);
      send_command(CMD_ADD, {32'h5a5a0000, k[31:0]}, 8'd0, 32'd0);
    end
    no_idle = 0;
    send_command(CMD_ADD, {32'h5a5a0000, 32'd7}, 8'd0, 32'd0);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    no_idle = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_ADD;
    in_content_hash = '0;
    in_slot_index = '0;
    in_frame_number = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = FIF_RESET;
    pool_reset();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_basic_commands();
    test_frame_delays();
    test_random_traffic();
    test_queue_overflow();
    test_pool_full();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rpdr_pkg.sv
sv/rpdr_slot_store.sv
sv/rpdr_pend_queue.sv
sv/refcounted_pool_deferred_reclaim.sv
tb/refcounted_pool_deferred_reclaim_test.sv
